// ===== sv/jwi_pkg.sv =====
// Package: shared constants, modes and controller states of the joint interpolator.
package jwi_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int AXES_DEF        = 6;
  localparam int FRAC_BITS_DEF   = 32;

  localparam int MODE_W  = 3;
  localparam int AXIS_W  = 26;
  localparam int ARR_W   = 20;
  localparam int TICK_W  = 32;
  localparam int DLY_W   = 16;
  localparam int CORR_W  = 27;
  localparam int LVL_W   = 5;
  localparam int OUT_LIMIT = 47185920;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 3'd0,
    MODE_START  = 3'd1,
    MODE_APPEND = 3'd2,
    MODE_STOP   = 3'd3,
    MODE_SYNC   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_POP_CHK,
    ST_POP_RD,
    ST_POP_LD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

endpackage

// ===== sv/joint_waypoint_interpolator_top.sv =====
// Top level: six-axis waypoint interpolator with queue, controller and serial divider.
//
//  channel | group        | content
//  input   | in_t*        | tuser: mode; tdata: axes, arrival, tick, delayed packets
//  result  | out_t*       | tdata: corrections, tick echo, moving, queue level
//
// On a tick while moving, the serial divider (NW = FRACTION_BITS+17 bits wide)
// runs once per axis. Reset (rst_n low, synchronous) clears the controller,
// queue pointers and motion state; the queue memory is not cleared.
// A result waits in the output register; the next word is taken meanwhile.
module joint_waypoint_interpolator_top #(
  parameter int QUEUE_DEPTH   = jwi_pkg::QUEUE_DEPTH_DEF,
  parameter int AXES          = jwi_pkg::AXES_DEF,
  parameter int FRACTION_BITS = jwi_pkg::FRAC_BITS_DEF,
  localparam int IN_W  = AXES * jwi_pkg::AXIS_W + jwi_pkg::ARR_W + jwi_pkg::TICK_W
                         + jwi_pkg::DLY_W,
  localparam int IN_DW = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W = AXES * jwi_pkg::CORR_W + jwi_pkg::TICK_W + 1 + jwi_pkg::LVL_W,
  localparam int OUT_DW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // axis_0..axis_N, arrival_ticks, tick_count, delayed_packets
  input  logic [IN_DW-1:0]            in_tdata,
  // mode
  input  logic [jwi_pkg::MODE_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // corr_0..corr_N, tick_echo, moving, queue_level
  output logic [OUT_DW-1:0]           out_tdata
);

  localparam int AW    = jwi_pkg::AXIS_W;
  localparam int SCALE = FRACTION_BITS - 16;
  localparam int TW    = FRACTION_BITS + 16;
  localparam int NW    = TW + 1;
  localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int XW    = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int EW    = AXES * AW + jwi_pkg::ARR_W;
  localparam int TKW   = jwi_pkg::TICK_W;
  localparam int ARW   = jwi_pkg::ARR_W;
  localparam int OB    = AXES * AW;

  localparam logic [NW-1:0] POS_MAX = NW'((65'd1 << (TW - 1)) - 1);
  localparam logic [NW-1:0] NEG_MAX = NW'(65'd1 << (TW - 1));
  localparam logic [NW-1:0] OLIM    = NW'(jwi_pkg::OUT_LIMIT);

  jwi_pkg::state_t state_r, state_nxt;

  logic signed [TW-1:0] tracked_r [AXES];
  logic signed [TW-1:0] lastcorr_r [AXES];
  logic signed [AW-1:0] target_r [AXES];
  logic [TKW-1:0]  target_tick_r;
  logic [TKW-1:0]  last_tick_r;
  logic            moving_r;
  logic [jwi_pkg::DLY_W-1:0] last_dly_r;
  logic [QW-1:0]   head_r;
  logic [QW:0]     fill_r;

  logic [EW-1:0]   qmem [QUEUE_DEPTH];
  logic [EW-1:0]   rd_r;

  logic [TKW-1:0]  tick_r;
  logic [jwi_pkg::DLY_W-1:0] dly_r;
  logic [XW-1:0]   ax_r;
  logic            neg_r;
  logic signed [jwi_pkg::CORR_W-1:0] corr_r [AXES];

  logic            out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic [OUT_DW-1:0] out_word;

  logic            in_acc;
  jwi_pkg::mode_t  in_mode;
  logic [ARW-1:0]  in_arr;
  logic [TKW-1:0]  in_tick;
  logic [jwi_pkg::DLY_W-1:0] in_dly;
  logic [TKW-1:0]  eta;
  logic            passed;
  logic [QW:0]     slot_sum;
  logic [QW-1:0]   slot;

  logic            div_start;
  logic            div_busy;
  logic [NW-1:0]   div_quot;
  logic signed [NW-1:0] diff;
  logic [NW-1:0]   diff_mag;
  logic [NW-1:0]   cmag;
  logic signed [TW-1:0] cval;
  logic signed [NW-1:0] tsum;
  logic signed [TW-1:0] tsat;
  logic [NW-1:0]   omag;
  logic [jwi_pkg::CORR_W-1:0] ocorr;
  logic            out_free;

  function automatic logic signed [TW-1:0] sat_sub(input logic signed [TW-1:0] x,
                                                   input logic signed [TW-1:0] y);
    logic signed [NW-1:0] d;
    d = NW'(x) - NW'(y);
    if (d[NW-1] != d[NW-2]) begin
      return d[NW-1] ? TW'(NEG_MAX) : TW'(POS_MAX);
    end
    return TW'(d);
  endfunction

  assign in_acc   = in_tvalid && in_tready;
  assign in_mode  = jwi_pkg::mode_t'(in_tuser);
  assign in_arr   = in_tdata[OB +: ARW];
  assign in_tick  = in_tdata[OB + ARW +: TKW];
  assign in_dly   = in_tdata[OB + ARW + TKW +: jwi_pkg::DLY_W];
  assign in_tready = (state_r == jwi_pkg::ST_IDLE);

  assign eta      = target_tick_r - tick_r;
  assign passed   = (eta == '0) || eta[TKW-1];
  assign slot_sum = {1'b0, head_r} + fill_r;
  assign slot     = (slot_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                    QW'(slot_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(slot_sum);
  assign out_free = !out_valid_r || out_tready;

  assign diff      = (NW'(signed'(target_r[ax_r])) <<< SCALE) - NW'(tracked_r[ax_r]);
  assign diff_mag  = diff[NW-1] ? NW'(-diff) : NW'(diff);
  assign div_start = (state_r == jwi_pkg::ST_DIV_GO);

  always_comb begin
    if (neg_r) begin
      cmag = (div_quot > NEG_MAX) ? NEG_MAX : div_quot;
    end else begin
      cmag = (div_quot > POS_MAX) ? POS_MAX : div_quot;
    end
    cval = neg_r ? TW'(-cmag) : TW'(cmag);
    tsum = NW'(tracked_r[ax_r]) + NW'(cval);
    if (tsum[NW-1] != tsum[NW-2]) begin
      tsat = tsum[NW-1] ? TW'(NEG_MAX) : TW'(POS_MAX);
    end else begin
      tsat = TW'(tsum);
    end
    omag  = cmag >> SCALE;
    omag  = (omag > OLIM) ? OLIM : omag;
    ocorr = neg_r ? jwi_pkg::CORR_W'(-omag) : jwi_pkg::CORR_W'(omag);
  end

  always_comb begin
    out_word = '0;
    for (int a = 0; a < AXES; a++) begin
      out_word[a*jwi_pkg::CORR_W +: jwi_pkg::CORR_W] = corr_r[a];
    end
    out_word[AXES*jwi_pkg::CORR_W +: TKW] = tick_r;
    out_word[AXES*jwi_pkg::CORR_W + TKW] = moving_r;
    out_word[AXES*jwi_pkg::CORR_W + TKW + 1 +: jwi_pkg::LVL_W] = jwi_pkg::LVL_W'(fill_r);
  end

  jwi_div #(.NW(NW), .DW(TKW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (diff_mag),
    .den   (eta),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jwi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      jwi_pkg::ST_IDLE: begin
        if (in_acc && in_mode == jwi_pkg::MODE_TICK) begin
          state_nxt = jwi_pkg::ST_DROP;
        end
      end
      jwi_pkg::ST_DROP: state_nxt = jwi_pkg::ST_POP_CHK;
      jwi_pkg::ST_POP_CHK: begin
        if (moving_r && passed && fill_r != '0) begin
          state_nxt = jwi_pkg::ST_POP_RD;
        end else if (moving_r && !passed) begin
          state_nxt = jwi_pkg::ST_DIV_GO;
        end else begin
          state_nxt = jwi_pkg::ST_EMIT;
        end
      end
      jwi_pkg::ST_POP_RD: state_nxt = jwi_pkg::ST_POP_LD;
      jwi_pkg::ST_POP_LD: state_nxt = jwi_pkg::ST_POP_CHK;
      jwi_pkg::ST_DIV_GO: state_nxt = jwi_pkg::ST_DIV_WAIT;
      jwi_pkg::ST_DIV_WAIT: begin
        if (!div_busy) begin
          state_nxt = (ax_r == XW'(AXES - 1)) ? jwi_pkg::ST_EMIT : jwi_pkg::ST_DIV_GO;
        end
      end
      jwi_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = jwi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = jwi_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r      <= 1'b0;
      head_r        <= '0;
      fill_r        <= '0;
      target_tick_r <= '0;
      last_tick_r   <= '0;
      last_dly_r    <= '0;
      out_valid_r   <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        tracked_r[a]  <= '0;
        lastcorr_r[a] <= '0;
        target_r[a]   <= '0;
      end
    end else begin
      if (state_r == jwi_pkg::ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        jwi_pkg::ST_IDLE: begin
          if (in_acc) begin
            case (in_mode)
              jwi_pkg::MODE_START: begin
                head_r <= '0;
                fill_r <= '0;
                for (int a = 0; a < AXES; a++) begin
                  target_r[a] <= in_tdata[a*AW +: AW];
                end
                target_tick_r <= last_tick_r + TKW'(in_arr);
                moving_r <= 1'b1;
              end
              jwi_pkg::MODE_APPEND: begin
                if (fill_r < (QW+1)'(QUEUE_DEPTH)) begin
                  fill_r <= fill_r + 1'b1;
                end
              end
              jwi_pkg::MODE_STOP: begin
                head_r   <= '0;
                fill_r   <= '0;
                moving_r <= 1'b0;
              end
              jwi_pkg::MODE_SYNC: begin
                head_r      <= '0;
                fill_r      <= '0;
                moving_r    <= 1'b0;
                last_tick_r <= in_tick;
                for (int a = 0; a < AXES; a++) begin
                  tracked_r[a] <= TW'(signed'(in_tdata[a*AW +: AW])) <<< SCALE;
                end
              end
              default: ;
            endcase
          end
        end
        jwi_pkg::ST_DROP: begin
          if (dly_r != last_dly_r) begin
            for (int a = 0; a < AXES; a++) begin
              tracked_r[a] <= sat_sub(tracked_r[a], lastcorr_r[a]);
            end
          end
          last_dly_r  <= dly_r;
          last_tick_r <= tick_r;
        end
        jwi_pkg::ST_POP_CHK: begin
          if (moving_r && passed && fill_r == '0) begin
            moving_r <= 1'b0;
          end
        end
        jwi_pkg::ST_POP_LD: begin
          for (int a = 0; a < AXES; a++) begin
            target_r[a] <= rd_r[a*AW +: AW];
          end
          target_tick_r <= last_tick_r + TKW'(rd_r[OB +: ARW]);
          head_r <= (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          fill_r <= fill_r - 1'b1;
        end
        jwi_pkg::ST_DIV_WAIT: begin
          if (!div_busy) begin
            lastcorr_r[ax_r] <= cval;
            tracked_r[ax_r]  <= tsat;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      jwi_pkg::ST_IDLE: begin
        if (in_acc) begin
          tick_r <= in_tick;
          dly_r  <= in_dly;
        end
      end
      jwi_pkg::ST_DROP: begin
        ax_r <= '0;
        for (int a = 0; a < AXES; a++) begin
          corr_r[a] <= '0;
        end
      end
      jwi_pkg::ST_DIV_GO: neg_r <= diff[NW-1];
      jwi_pkg::ST_DIV_WAIT: begin
        if (!div_busy) begin
          corr_r[ax_r] <= ocorr;
          ax_r <= ax_r + 1'b1;
        end
      end
      jwi_pkg::ST_EMIT: begin
        if (out_free) begin
          out_data_r <= out_word;
        end
      end
      default: ;
    endcase
  end

  // waypoint queue memory
  always_ff @(posedge clk) begin
    if (state_r == jwi_pkg::ST_IDLE && in_acc && in_mode == jwi_pkg::MODE_APPEND &&
        fill_r < (QW+1)'(QUEUE_DEPTH)) begin
      qmem[slot] <= in_tdata[EW-1:0];
    end
    if (state_r == jwi_pkg::ST_POP_RD) begin
      rd_r <= qmem[head_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (QW+1)'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jwi_pkg::ST_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

  a_cmd_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode != jwi_pkg::MODE_TICK) |=> !$rose(out_valid_r))
    else $error("word produced for a command");

  a_pop_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jwi_pkg::ST_POP_RD) |-> (moving_r && fill_r != '0))
    else $error("pop without queued waypoint");

endmodule

// ===== sv/jwi_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module jwi_div #(
  parameter int NW = 49,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  assign rem_sh  = {rem_r, quo_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;

endmodule

// ===== tb/joint_waypoint_interpolator_top_test.sv =====
// Testbench: random and directed waypoint/tick streams checked against a local interpolator model.
module joint_waypoint_interpolator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAX = 6;
  localparam int QD = 16;
  localparam int SHIFT_EXP = 65536;
  localparam longint TRK_MAX = (64'sd1 <<< 47) - 1;
  localparam longint TRK_MIN = -TRK_MAX - 1;
  localparam longint AX_LIM = 23592960;
  localparam int LIMIT_CYCLES = 4000000;

  typedef struct {
    logic [2:0] mode;
    logic signed [jwi_pkg::AXIS_W-1:0] axis [NAX];
    logic [jwi_pkg::ARR_W-1:0] arrival;
    logic [jwi_pkg::TICK_W-1:0] tick;
    logic [jwi_pkg::DLY_W-1:0] delayed;
    bit drain;
    int phase;
  } cmd_word_t;

  typedef struct {
    logic signed [jwi_pkg::CORR_W-1:0] corr [NAX];
    logic [jwi_pkg::TICK_W-1:0] tick;
    logic moving;
    logic [jwi_pkg::LVL_W-1:0] level;
  } corr_word_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [223:0] in_tdata = '0;
  logic [jwi_pkg::MODE_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [199:0] out_tdata;

  joint_waypoint_interpolator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // interpolator state
  longint tracked [NAX];
  longint last_corr [NAX];
  longint target_pos [NAX];
  logic [31:0] target_tick = '0, last_tick = '0;
  bit moving_st;
  logic [15:0] last_dly = '0;
  longint wp_pos [QD][NAX];
  logic [19:0] wp_arr [QD];
  int wp_head, wp_fill;

  cmd_word_t pending[$];
  corr_word_t corr_expected[$];
  cmd_word_t cur;
  int errors = 0, words_in = 0, words_out = 0, moving_out = 0, cycles = 0;
  int cur_phase = 0;

  function automatic longint sat_trk(longint v);
    return v < TRK_MIN ? TRK_MIN : (v > TRK_MAX ? TRK_MAX : v);
  endfunction

  function automatic bit deadline_gone(logic [31:0] t);
    logic [31:0] d;
    d = target_tick - t;
    return d == 0 || d[31];
  endfunction

  function automatic void go_to(longint p [NAX], logic [19:0] arr);
    for (int a = 0; a < NAX; a++) target_pos[a] = p[a];
    target_tick = last_tick + 32'(arr);
    moving_st = 1;
  endfunction

  function automatic bit interp_step(cmd_word_t w, output corr_word_t r);
    longint p [NAX];
    longint c, eta;
    logic [31:0] d;
    for (int a = 0; a < NAX; a++) p[a] = longint'(w.axis[a]);
    case (w.mode)
      jwi_pkg::MODE_START: begin
        wp_head = 0;
        wp_fill = 0;
        go_to(p, w.arrival);
        return 0;
      end
      jwi_pkg::MODE_APPEND: begin
        if (wp_fill < QD) begin
          for (int a = 0; a < NAX; a++) wp_pos[(wp_head + wp_fill) % QD][a] = p[a];
          wp_arr[(wp_head + wp_fill) % QD] = w.arrival;
          wp_fill++;
        end
        return 0;
      end
      jwi_pkg::MODE_STOP, jwi_pkg::MODE_SYNC: begin
        wp_head = 0;
        wp_fill = 0;
        moving_st = 0;
        if (w.mode == jwi_pkg::MODE_SYNC) begin
          last_tick = w.tick;
          for (int a = 0; a < NAX; a++) tracked[a] = p[a] * SHIFT_EXP;
        end
        return 0;
      end
      jwi_pkg::MODE_TICK: ;
      default: return 0;
    endcase
    if (w.delayed != last_dly)
      for (int a = 0; a < NAX; a++) tracked[a] = sat_trk(tracked[a] - last_corr[a]);
    last_dly = w.delayed;
    last_tick = w.tick;
    if (moving_st) begin
      while (wp_fill > 0 && deadline_gone(w.tick)) begin
        go_to(wp_pos[wp_head], wp_arr[wp_head]);
        wp_head = (wp_head + 1) % QD;
        wp_fill--;
      end
      if (deadline_gone(w.tick)) moving_st = 0;
    end
    for (int a = 0; a < NAX; a++) begin
      c = 0;
      if (moving_st) begin
        d = target_tick - w.tick;
        eta = longint'({32'b0, d});
        c = sat_trk((target_pos[a] * SHIFT_EXP - tracked[a]) / eta);
        last_corr[a] = c;
        tracked[a] = sat_trk(tracked[a] + c);
        c = c / SHIFT_EXP;
        c = c < -jwi_pkg::OUT_LIMIT ? -jwi_pkg::OUT_LIMIT :
            (c > jwi_pkg::OUT_LIMIT ? jwi_pkg::OUT_LIMIT : c);
      end
      r.corr[a] = jwi_pkg::CORR_W'(c);
    end
    r.tick = w.tick;
    r.moving = moving_st;
    r.level = jwi_pkg::LVL_W'(wp_fill);
    return 1;
  endfunction

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
  end

  // driver
  always @(posedge clk) begin
    corr_word_t r;
    bit go;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        words_in++;
        cur_phase = cur.phase;
        if (interp_step(cur, r)) corr_expected.push_back(r);
      end
      if (!(in_tvalid && !in_tready)) begin
        go = pending.size() > 0;
        if (go && pending[0].drain && corr_expected.size() != 0) go = 0;
        if (go && (pending[0].phase == 1 && $urandom_range(99) < 45 ||
                   pending[0].phase == 3 && $urandom_range(99) < 12)) go = 0;
        if (go) begin
          cur = pending.pop_front();
          in_tvalid <= 1;
          in_tuser <= cur.mode;
          in_tdata <= {cur.delayed, cur.tick, cur.arrival, cur.axis[5], cur.axis[4],
                       cur.axis[3], cur.axis[2], cur.axis[1], cur.axis[0]};
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    corr_word_t e;
    logic signed [jwi_pkg::CORR_W-1:0] got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        words_out++;
        if (corr_expected.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_tdata);
          errors++;
        end else begin
          e = corr_expected.pop_front();
          if (e.moving) moving_out++;
          for (int a = 0; a < NAX; a++) begin
            got = out_tdata[a*jwi_pkg::CORR_W +: jwi_pkg::CORR_W];
            if (got !== e.corr[a]) begin
              $display("%0t: corr_%0d expected %0d got %0d", $time, a, e.corr[a], got);
              errors++;
            end
          end
          if (out_tdata[193:162] !== e.tick) begin
            $display("%0t: tick_echo expected %h got %h", $time, e.tick, out_tdata[193:162]);
            errors++;
          end
          if (out_tdata[194] !== e.moving) begin
            $display("%0t: moving expected %b got %b", $time, e.moving, out_tdata[194]);
            errors++;
          end
          if (out_tdata[199:195] !== e.level) begin
            $display("%0t: queue_level expected %0d got %0d", $time, e.level,
                     out_tdata[199:195]);
            errors++;
          end
        end
      end
      out_tready <= !((cur_phase == 2 && $urandom_range(99) < 45) ||
                      (cur_phase == 3 && $urandom_range(99) < 12));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  logic [31:0] tc = 32'd0;
  logic [15:0] dly = 16'd0;
  int ph = 0;

  task automatic add(logic [2:0] m, longint ax [NAX], logic [19:0] arr, logic [31:0] t,
                     logic [15:0] dl, bit dr = 0);
    cmd_word_t w;
    w.mode = m;
    for (int a = 0; a < NAX; a++) w.axis[a] = jwi_pkg::AXIS_W'(ax[a]);
    w.arrival = arr;
    w.tick = t;
    w.delayed = dl;
    w.drain = dr;
    w.phase = ph;
    pending.push_back(w);
  endtask

  function automatic longint rnd_axis();
    case ($urandom_range(5))
      0: return AX_LIM;
      1: return -AX_LIM;
      default: return longint'($urandom_range(2 * AX_LIM)) - AX_LIM;
    endcase
  endfunction

  task automatic tick_now(bit jump_dly = 0);
    longint z [NAX];
    for (int a = 0; a < NAX; a++) z[a] = rnd_axis();
    tc = tc + 1;
    if (jump_dly) dly = 16'($urandom);
    add(jwi_pkg::MODE_TICK, z, 20'($urandom), tc, dly);
  endtask

  initial begin
    longint hi [NAX], lo [NAX], rp [NAX];
    int n;
    for (int a = 0; a < NAX; a++) begin
      hi[a] = AX_LIM;
      lo[a] = -AX_LIM;
    end
    // directed
    add(jwi_pkg::MODE_TICK, hi, 20'hFFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    tc = 32'hFFFF_FFF8;
    add(jwi_pkg::MODE_SYNC, hi, 20'd0, tc, 16'd0);
    add(jwi_pkg::MODE_START, lo, 20'd1, 32'd0, 16'd0);
    tick_now();
    add(jwi_pkg::MODE_START, hi, 20'd6, 32'd0, 16'd0);
    tick_now();
    tick_now(1);
    add(jwi_pkg::MODE_START, lo, 20'd0, 32'd0, 16'd0);
    tick_now();
    add(jwi_pkg::MODE_START, hi, 20'd3, 32'd0, 16'd0);
    for (int i = 0; i < 17; i++) begin
      for (int a = 0; a < NAX; a++) rp[a] = rnd_axis();
      add(jwi_pkg::MODE_APPEND, rp, i == 0 ? 20'd0 : 20'd2, 32'd0, 16'd0);
    end
    add(3'd5, hi, 20'hFFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    add(3'd6, lo, 20'd0, 32'd0, 16'd0);
    add(3'd7, hi, 20'd1, 32'd1, 16'd1);
    for (int i = 0; i < 12; i++) tick_now(i == 5);
    add(jwi_pkg::MODE_START, hi, 20'hFFFFF, 32'd0, 16'd0);
    tick_now();
    add(jwi_pkg::MODE_STOP, lo, 20'd0, 32'd0, 16'd0, 1);
    tick_now(1);
    // random
    n = pending.size();
    while (n < 500) begin
      ph = (n / 50) % 4;
      if ($urandom_range(9) < 8) begin
        if ($urandom_range(9) == 0) tc = $urandom;
        if ($urandom_range(3) == 0) begin
          for (int a = 0; a < NAX; a++) rp[a] = rnd_axis();
          add(jwi_pkg::MODE_SYNC, rp, 20'($urandom), tc, 16'($urandom));
        end
        for (int a = 0; a < NAX; a++) rp[a] = rnd_axis();
        add(jwi_pkg::MODE_START, rp, 20'($urandom_range(12)), 32'($urandom),
            16'($urandom), $urandom_range(15) == 0);
        repeat ($urandom_range(0, $urandom_range(3) == 0 ? 18 : 4)) begin
          for (int a = 0; a < NAX; a++) rp[a] = rnd_axis();
          add(jwi_pkg::MODE_APPEND, rp,
              $urandom_range(19) == 0 ? 20'($urandom) : 20'($urandom_range(8)),
              32'($urandom), 16'($urandom));
        end
        repeat ($urandom_range(1, 25)) tick_now($urandom_range(9) == 0);
        if ($urandom_range(4) == 0) begin
          for (int a = 0; a < NAX; a++) rp[a] = rnd_axis();
          add(jwi_pkg::MODE_STOP, rp, 20'($urandom), 32'($urandom), 16'($urandom));
          tick_now();
        end
      end else begin
        for (int a = 0; a < NAX; a++) rp[a] = rnd_axis();
        add(3'($urandom_range(7)), rp, 20'($urandom), 32'($urandom), 16'($urandom));
      end
      n = pending.size() + words_in;
    end
    wait (rst_n);
    while (pending.size() != 0 || in_tvalid || corr_expected.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("%0d words sent, %0d results checked (%0d while moving),", words_in, words_out,
             moving_out);
    $display("covering start/append/stop/sync, queue overflow, tick wrap and packet loss.");
    if (errors == 0 && corr_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/jwi_pkg.sv
sv/jwi_div.sv
sv/joint_waypoint_interpolator_top.sv
tb/joint_waypoint_interpolator_top_test.sv
